/* rtl/core/pid_controller_q15_defines.svh */
// Assertion macros shared by the PID controller checkers.
`ifndef PID_CONTROLLER_Q15_DEFINES_SVH
`define PID_CONTROLLER_Q15_DEFINES_SVH

// Check that a condition leads to a consequence in the next cycle.
`define PIDQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define PIDQ_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check what reset leaves behind in the next cycle.
`define PIDQ_ASSERT_RESET(label, clk, rst, cons, msg) \
  label: assert property (@(posedge clk) (rst) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/pidq_pkg.sv */
// Shared widths, reset values, register indexes, unit request types and helpers.
package pidq_pkg;

  // Field and datapath widths
  localparam int DATA_W    = 16;
  localparam int GAIN_W    = 15;
  localparam int ERR_W     = 17;
  localparam int DIFF_W    = 18;
  localparam int SUM_W     = 32;
  localparam int MCAND_W   = 33;
  localparam int MPLIER_W  = GAIN_W;
  localparam int PROD_W    = MCAND_W + MPLIER_W;
  localparam int Q15_SHIFT = 15;
  localparam int TERM_W    = PROD_W - Q15_SHIFT;
  localparam int TOTAL_W   = TERM_W + 2;
  localparam int DIVD_W    = PROD_W - 1;
  localparam int DIVS_W    = GAIN_W;
  localparam int IDX_W     = 3;
  localparam int MUL_CNT_W = $clog2(MPLIER_W);
  localparam int DIV_CNT_W = $clog2(DIVD_W);
  localparam int Q15_FRAC_MASK = (1 << Q15_SHIFT) - 1;

  // Register reset values
  localparam logic [GAIN_W-1:0]        KP_RESET      = GAIN_W'(9000);
  localparam logic [GAIN_W-1:0]        KI_RESET      = GAIN_W'(200);
  localparam logic [GAIN_W-1:0]        KD_RESET      = GAIN_W'(0);
  localparam logic signed [DATA_W-1:0] OUT_MIN_RESET = -DATA_W'(4000);
  localparam logic signed [DATA_W-1:0] OUT_MAX_RESET = DATA_W'(4000);

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_KP      = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_KI      = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_KD      = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_OUT_MIN = IDX_W'(3);
  localparam logic [IDX_W-1:0] REG_OUT_MAX = IDX_W'(4);

  // Serial multiplier request and response
  typedef struct packed {
    logic                       start;
    logic signed [MCAND_W-1:0]  mcand;
    logic [MPLIER_W-1:0]        mplier;
  } mul_req_t;

  typedef struct packed {
    logic                      done;
    logic signed [PROD_W-1:0]  product;
  } mul_rsp_t;

  // Serial divider request and response
  typedef struct packed {
    logic                start;
    logic [DIVD_W-1:0]   dividend;
    logic [DIVS_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [DIVD_W-1:0]   quotient;
  } div_rsp_t;

  // Divide a product by 32768, truncating toward zero
  function automatic logic signed [TERM_W-1:0] q15_trunc(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] adj;
    adj = p[PROD_W-1] ? p + PROD_W'(Q15_FRAC_MASK) : p;
    return adj[PROD_W-1:Q15_SHIFT];
  endfunction

  // Clamp, testing the upper bound first
  function automatic logic signed [PROD_W-1:0] clamp_hi_lo(input logic signed [PROD_W-1:0] v,
                                                           input logic signed [PROD_W-1:0] hi,
                                                           input logic signed [PROD_W-1:0] lo);
    logic signed [PROD_W-1:0] r;
    if (v > hi) begin
      r = hi;
    end else if (v < lo) begin
      r = lo;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Magnitude of a signed 16-bit limit
  function automatic logic [DATA_W:0] limit_mag(input logic signed [DATA_W-1:0] v);
    logic signed [DATA_W:0] x;
    x = (DATA_W+1)'(v);
    return x[DATA_W] ? -x : x;
  endfunction

endpackage

/* rtl/core/pidq_mul.sv */
// Bit-serial shift-add multiplier: signed multiplicand by unsigned gain, one gain bit a cycle.
module pidq_mul (
  input  logic               clk,
  input  logic               rst,
  input  pidq_pkg::mul_req_t req,
  output pidq_pkg::mul_rsp_t rsp
);

  logic                                   busy;
  logic                                   done;
  logic [pidq_pkg::MUL_CNT_W-1:0]         cnt;
  logic signed [pidq_pkg::MCAND_W-1:0]    mcand;
  logic [pidq_pkg::MPLIER_W-1:0]          mplier;
  logic signed [pidq_pkg::PROD_W-1:0]     acc;
  logic signed [pidq_pkg::PROD_W-1:0]     addend;

  // Add the multiplicand when the top gain bit is set
  assign addend = mplier[pidq_pkg::MPLIER_W-1] ? pidq_pkg::PROD_W'(mcand) : '0;

  // Control: load on request, shift one gain bit per cycle, flag the last step
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == pidq_pkg::MUL_CNT_W'(pidq_pkg::MPLIER_W - 1))) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath: accumulate MSB first
  always_ff @(posedge clk) begin
    if (req.start) begin
      cnt    <= '0;
      acc    <= '0;
      mcand  <= req.mcand;
      mplier <= req.mplier;
    end else if (busy) begin
      acc    <= (acc <<< 1) + addend;
      mplier <= mplier << 1;
      cnt    <= cnt + pidq_pkg::MUL_CNT_W'(1);
    end
  end

  assign rsp.done    = done;
  assign rsp.product = acc;

endmodule

/* rtl/core/pidq_div.sv */
// Bit-serial restoring divider: unsigned dividend by unsigned gain, one quotient bit a cycle.
module pidq_div (
  input  logic               clk,
  input  logic               rst,
  input  pidq_pkg::div_req_t req,
  output pidq_pkg::div_rsp_t rsp
);

  logic                             busy;
  logic                             done;
  logic [pidq_pkg::DIV_CNT_W-1:0]   cnt;
  logic [pidq_pkg::DIVD_W-1:0]      quo;
  logic [pidq_pkg::DIVS_W-1:0]      rem;
  logic [pidq_pkg::DIVS_W-1:0]      divisor;
  logic [pidq_pkg::DIVS_W:0]        trial;
  logic [pidq_pkg::DIVS_W+1:0]      diff;
  logic                             fits;

  // Bring down the next dividend bit and trial-subtract
  assign trial = {rem, quo[pidq_pkg::DIVD_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, divisor};
  assign fits  = ~diff[pidq_pkg::DIVS_W+1];

  // Control: load on request, one step per cycle, flag the last step
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == pidq_pkg::DIV_CNT_W'(pidq_pkg::DIVD_W - 1))) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath: shift dividend out and quotient bits in
  always_ff @(posedge clk) begin
    if (req.start) begin
      cnt     <= '0;
      rem     <= '0;
      quo     <= req.dividend;
      divisor <= req.divisor;
    end else if (busy) begin
      rem <= fits ? diff[pidq_pkg::DIVS_W-1:0] : trial[pidq_pkg::DIVS_W-1:0];
      quo <= {quo[pidq_pkg::DIVD_W-2:0], fits};
      cnt <= cnt + pidq_pkg::DIV_CNT_W'(1);
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

/* rtl/core/pid_controller_q15.sv */
// No new sample is taken until the last result is loaded into the drive register,
// which waits while a result is stalled. Each of the three gain products is formed
// in the 15-step serial multiplier. A sample after a change of ki, out_min or out_max,
// with ki nonzero, first runs two 47-step serial bound divisions, after a rescale of
// the stored sum if ki moved from nonzero; with ki zero the bounds clear at once.
// Synchronous rst restores register defaults, clears the loop state and drops
// drive_valid; a sample can be taken on the first cycle after reset.
module pid_controller_q15 (
  input  logic                                 clk,
  input  logic                                 rst,
  // sample channel
  input  logic                                 sample_valid,
  output logic                                 sample_stall,
  input  logic signed [pidq_pkg::DATA_W-1:0]   reference,
  input  logic signed [pidq_pkg::DATA_W-1:0]   measured,
  // drive channel
  output logic                                 drive_valid,
  input  logic                                 drive_stall,
  output logic signed [pidq_pkg::DATA_W-1:0]   drive,
  // configuration channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pidq_pkg::IDX_W-1:0]           cfg_index,
  input  logic [pidq_pkg::DATA_W-1:0]          cfg_data
);

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b000_0000_0001,
    ST_RS_MUL = 11'b000_0000_0010,
    ST_RS_DIV = 11'b000_0000_0100,
    ST_LIM_HI = 11'b000_0000_1000,
    ST_LIM_LO = 11'b000_0001_0000,
    ST_CLAMP  = 11'b000_0010_0000,
    ST_P_MUL  = 11'b000_0100_0000,
    ST_I_MUL  = 11'b000_1000_0000,
    ST_D_MUL  = 11'b001_0000_0000,
    ST_SUM    = 11'b010_0000_0000,
    ST_OUT    = 11'b100_0000_0000
  } state_t;

  state_t state;
  logic   launch;

  // Configuration registers
  logic [pidq_pkg::GAIN_W-1:0]        kp;
  logic [pidq_pkg::GAIN_W-1:0]        ki;
  logic [pidq_pkg::GAIN_W-1:0]        kd;
  logic signed [pidq_pkg::DATA_W-1:0] out_min;
  logic signed [pidq_pkg::DATA_W-1:0] out_max;

  // Loop state
  logic signed [pidq_pkg::SUM_W-1:0]  integral_sum;
  logic signed [pidq_pkg::ERR_W-1:0]  previous_error;
  logic signed [pidq_pkg::SUM_W-1:0]  integral_upper;
  logic signed [pidq_pkg::SUM_W-1:0]  integral_lower;
  logic [pidq_pkg::GAIN_W-1:0]        last_ki;
  logic signed [pidq_pkg::DATA_W-1:0] last_upper;
  logic signed [pidq_pkg::DATA_W-1:0] last_lower;

  // Per-sample working registers
  logic signed [pidq_pkg::ERR_W-1:0]   err;
  logic signed [pidq_pkg::MCAND_W-1:0] isum_raw;
  logic signed [pidq_pkg::TERM_W-1:0]  p_term;
  logic signed [pidq_pkg::TERM_W-1:0]  i_term;
  logic signed [pidq_pkg::TERM_W-1:0]  d_term;
  logic signed [pidq_pkg::TOTAL_W-1:0] total;
  logic signed [pidq_pkg::PROD_W-1:0]  rescaled;
  logic [pidq_pkg::DIVD_W-1:0]         rs_mag;
  logic                                rs_neg;

  // Combinational helpers
  logic                                need_rc;
  logic                                do_rescale;
  logic signed [pidq_pkg::DIFF_W-1:0]  err_diff;
  logic signed [pidq_pkg::PROD_W-1:0]  prod_abs;
  logic signed [pidq_pkg::PROD_W-1:0]  quo_ext;
  logic                                lim_neg;
  logic signed [pidq_pkg::PROD_W-1:0]  bound_q;
  logic signed [pidq_pkg::PROD_W-1:0]  rs_clamped;
  logic signed [pidq_pkg::PROD_W-1:0]  isum_clamped;
  logic signed [pidq_pkg::PROD_W-1:0]  drive_clamped;

  pidq_pkg::mul_req_t mul_req;
  pidq_pkg::mul_rsp_t mul_rsp;
  pidq_pkg::div_req_t div_req;
  pidq_pkg::div_rsp_t div_rsp;

  pidq_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  pidq_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign sample_stall = (state != ST_IDLE);
  assign cfg_ready    = 1'b1;

  // Detect a change of ki or the output limits since the last bound recompute
  assign need_rc    = (ki != last_ki) || (out_max != last_upper) || (out_min != last_lower);
  assign do_rescale = (last_ki != '0) && (last_ki != ki);

  assign err_diff = pidq_pkg::DIFF_W'(err) - pidq_pkg::DIFF_W'(previous_error);
  assign prod_abs = mul_rsp.product[pidq_pkg::PROD_W-1] ? -mul_rsp.product : mul_rsp.product;
  assign quo_ext  = pidq_pkg::PROD_W'(div_rsp.quotient);
  assign lim_neg  = (state == ST_LIM_HI) ? out_max[pidq_pkg::DATA_W-1]
                                         : out_min[pidq_pkg::DATA_W-1];
  assign bound_q  = lim_neg ? -quo_ext : quo_ext;

  assign rs_clamped = pidq_pkg::clamp_hi_lo(rescaled,
                                            pidq_pkg::PROD_W'(integral_upper),
                                            pidq_pkg::PROD_W'(integral_lower));
  assign isum_clamped = pidq_pkg::clamp_hi_lo(pidq_pkg::PROD_W'(isum_raw),
                                              pidq_pkg::PROD_W'(integral_upper),
                                              pidq_pkg::PROD_W'(integral_lower));
  assign drive_clamped = pidq_pkg::clamp_hi_lo(pidq_pkg::PROD_W'(total),
                                               pidq_pkg::PROD_W'(out_max),
                                               pidq_pkg::PROD_W'(out_min));

  // Issue requests to the serial units on the first cycle of each phase
  always_comb begin
    mul_req = '0;
    div_req = '0;
    unique case (state)
      ST_RS_MUL: begin
        mul_req.start  = launch;
        mul_req.mcand  = pidq_pkg::MCAND_W'(integral_sum);
        mul_req.mplier = last_ki;
      end
      ST_RS_DIV: begin
        div_req.start    = launch;
        div_req.dividend = rs_mag;
        div_req.divisor  = ki;
      end
      ST_LIM_HI: begin
        div_req.start    = launch;
        div_req.dividend = pidq_pkg::DIVD_W'({pidq_pkg::limit_mag(out_max),
                                              pidq_pkg::Q15_SHIFT'(0)});
        div_req.divisor  = ki;
      end
      ST_LIM_LO: begin
        div_req.start    = launch;
        div_req.dividend = pidq_pkg::DIVD_W'({pidq_pkg::limit_mag(out_min),
                                              pidq_pkg::Q15_SHIFT'(0)});
        div_req.divisor  = ki;
      end
      ST_P_MUL: begin
        mul_req.start  = launch;
        mul_req.mcand  = pidq_pkg::MCAND_W'(err);
        mul_req.mplier = kp;
      end
      ST_I_MUL: begin
        mul_req.start  = launch;
        mul_req.mcand  = pidq_pkg::MCAND_W'(integral_sum);
        mul_req.mplier = ki;
      end
      ST_D_MUL: begin
        mul_req.start  = launch;
        mul_req.mcand  = pidq_pkg::MCAND_W'(err_diff);
        mul_req.mplier = kd;
      end
      default: begin
      end
    endcase
  end

  // Configuration writes, sequencer and result handoff
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      launch         <= 1'b0;
      drive_valid    <= 1'b0;
      kp             <= pidq_pkg::KP_RESET;
      ki             <= pidq_pkg::KI_RESET;
      kd             <= pidq_pkg::KD_RESET;
      out_min        <= pidq_pkg::OUT_MIN_RESET;
      out_max        <= pidq_pkg::OUT_MAX_RESET;
      integral_sum   <= '0;
      previous_error <= '0;
      integral_upper <= '0;
      integral_lower <= '0;
      last_ki        <= '0;
      last_upper     <= '0;
      last_lower     <= '0;
    end else begin
      // Write a configuration register; drop unknown indexes
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          pidq_pkg::REG_KP:      kp      <= cfg_data[pidq_pkg::GAIN_W-1:0];
          pidq_pkg::REG_KI:      ki      <= cfg_data[pidq_pkg::GAIN_W-1:0];
          pidq_pkg::REG_KD:      kd      <= cfg_data[pidq_pkg::GAIN_W-1:0];
          pidq_pkg::REG_OUT_MIN: out_min <= cfg_data;
          pidq_pkg::REG_OUT_MAX: out_max <= cfg_data;
          default: begin
          end
        endcase
      end

      // Release the drive register once the request is taken
      if (drive_valid && !drive_stall) begin
        drive_valid <= 1'b0;
      end

      launch <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (sample_valid) begin
            err    <= pidq_pkg::ERR_W'(reference) - pidq_pkg::ERR_W'(measured);
            launch <= 1'b1;
            if (need_rc && (ki != '0)) begin
              if (do_rescale) begin
                state <= ST_RS_MUL;
              end else begin
                rescaled <= pidq_pkg::PROD_W'(integral_sum);
                state    <= ST_LIM_HI;
              end
            end else begin
              // Zero integral gain clears the sum and its bounds at once
              if (need_rc) begin
                integral_sum   <= '0;
                integral_upper <= '0;
                integral_lower <= '0;
                last_ki        <= ki;
                last_upper     <= out_max;
                last_lower     <= out_min;
              end
              state <= ST_P_MUL;
            end
          end
        end
        ST_RS_MUL: begin
          if (mul_rsp.done) begin
            rs_neg <= mul_rsp.product[pidq_pkg::PROD_W-1];
            rs_mag <= prod_abs[pidq_pkg::DIVD_W-1:0];
            launch <= 1'b1;
            state  <= ST_RS_DIV;
          end
        end
        ST_RS_DIV: begin
          if (div_rsp.done) begin
            rescaled <= rs_neg ? -quo_ext : quo_ext;
            launch   <= 1'b1;
            state    <= ST_LIM_HI;
          end
        end
        ST_LIM_HI: begin
          if (div_rsp.done) begin
            integral_upper <= bound_q[pidq_pkg::SUM_W-1:0];
            launch         <= 1'b1;
            state          <= ST_LIM_LO;
          end
        end
        ST_LIM_LO: begin
          if (div_rsp.done) begin
            integral_lower <= bound_q[pidq_pkg::SUM_W-1:0];
            state          <= ST_CLAMP;
          end
        end
        ST_CLAMP: begin
          // Fit the carried sum into the new bounds and record what they follow from
          integral_sum <= rs_clamped[pidq_pkg::SUM_W-1:0];
          last_ki      <= ki;
          last_upper   <= out_max;
          last_lower   <= out_min;
          launch       <= 1'b1;
          state        <= ST_P_MUL;
        end
        ST_P_MUL: begin
          if (launch) begin
            isum_raw <= pidq_pkg::MCAND_W'(integral_sum) + pidq_pkg::MCAND_W'(err);
          end else if (mul_rsp.done) begin
            p_term       <= pidq_pkg::q15_trunc(mul_rsp.product);
            integral_sum <= (ki == '0) ? '0 : isum_clamped[pidq_pkg::SUM_W-1:0];
            launch       <= 1'b1;
            state        <= ST_I_MUL;
          end
        end
        ST_I_MUL: begin
          if (mul_rsp.done) begin
            i_term <= pidq_pkg::q15_trunc(mul_rsp.product);
            launch <= 1'b1;
            state  <= ST_D_MUL;
          end
        end
        ST_D_MUL: begin
          if (launch) begin
            previous_error <= err;
          end else if (mul_rsp.done) begin
            d_term <= pidq_pkg::q15_trunc(mul_rsp.product);
            state  <= ST_SUM;
          end
        end
        ST_SUM: begin
          total <= pidq_pkg::TOTAL_W'(p_term) + pidq_pkg::TOTAL_W'(i_term)
                 + pidq_pkg::TOTAL_W'(d_term);
          state <= ST_OUT;
        end
        ST_OUT: begin
          // Hold until the drive register is free
          if (!drive_valid || !drive_stall) begin
            drive       <= drive_clamped[pidq_pkg::DATA_W-1:0];
            drive_valid <= 1'b1;
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/core/pidq_chk.sv */
// Port-level checker for the PID controller and its bind to the top level.
`include "pid_controller_q15_defines.svh"

module pidq_chk (
  input logic                          clk,
  input logic                          rst,
  input logic                          sample_valid,
  input logic                          sample_stall,
  input logic                          drive_valid,
  input logic                          drive_stall,
  input logic [pidq_pkg::DATA_W-1:0]   drive
);

  // A stalled result request stays put
  `PIDQ_ASSERT_NEXT(a_drive_hold, clk, rst, drive_valid && drive_stall, drive_valid && $stable(drive), "drive request changed while stalled")

  // An accepted sample keeps the block busy in the next cycle
  `PIDQ_ASSERT_NEXT(a_busy_after_accept, clk, rst, sample_valid && !sample_stall, sample_stall, "sample channel open right after accept")

  // A new result appears only as the block returns to taking samples
  `PIDQ_ASSERT_SAME(a_result_frees_input, clk, rst, $rose(drive_valid), !sample_stall, "result posted while still busy")

  // Reset leaves no result pending and the sample channel open
  `PIDQ_ASSERT_RESET(a_reset_state, clk, rst, !drive_valid && !sample_stall, "reset did not clear handshake state")

endmodule

bind pid_controller_q15 pidq_chk u_pidq_chk (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample_valid),
  .sample_stall (sample_stall),
  .drive_valid  (drive_valid),
  .drive_stall  (drive_stall),
  .drive        (drive)
);

/* bench/pid_controller_q15_test.sv */
// Self-checking testbench for the Q15 PID controller with integral anti-windup.
`timescale 1ns / 100ps

module pid_controller_q15_test;
  import pidq_pkg::*;

  localparam int     CYCLE_LIMIT = 1_000_000;
  localparam int     DRAIN_WAIT  = 60;
  localparam int     RAND_PHASES = 10;
  localparam int     PHASE_ITEMS = 100;
  localparam longint Q15_ONE     = 64'sd1 << Q15_SHIFT;
  localparam int     REG_COUNT   = 5;
  localparam logic [IDX_W-1:0] REG_LAST_CODE = IDX_W'((1 << IDX_W) - 1);

  typedef struct {
    logic signed [DATA_W-1:0] reference;
    logic signed [DATA_W-1:0] measured;
  } sample_t;

  // Block ports
  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       sample_valid = 1'b0;
  logic                       sample_stall;
  logic signed [DATA_W-1:0]   reference = '0;
  logic signed [DATA_W-1:0]   measured = '0;
  logic                       drive_valid;
  logic                       drive_stall = 1'b0;
  logic signed [DATA_W-1:0]   drive;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [IDX_W-1:0]           cfg_index = '0;
  logic [DATA_W-1:0]          cfg_data = '0;

  // Register shadow
  int kp_gain  = KP_RESET;
  int ki_gain  = KI_RESET;
  int kd_gain  = KD_RESET;
  int drive_lo = OUT_MIN_RESET;
  int drive_hi = OUT_MAX_RESET;

  // Loop state shadow
  longint accum      = 0;
  longint last_error = 0;
  longint accum_hi   = 0;
  longint accum_lo   = 0;
  int     bound_ki   = 0;
  int     bound_hi   = 0;
  int     bound_lo   = 0;

  // Request and result bookkeeping
  sample_t                  pending_q[$];
  logic signed [DATA_W-1:0] drive_q[$];
  sample_t                  next_sample;
  logic signed [DATA_W-1:0] want_drive;
  logic                     sample_fire = 1'b0;
  logic                     quiet = 1'b0;
  int                       gap_left = 0;
  int                       stall_left = 0;
  int                       setpoint = 0;
  int                       errors = 0;
  int                       accepted = 0;
  int                       checked = 0;
  int                       reg_writes = 0;
  int                       settings = 1;
  int                       cycles = 0;

  pid_controller_q15 u_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .reference    (reference),
    .measured     (measured),
    .drive_valid  (drive_valid),
    .drive_stall  (drive_stall),
    .drive        (drive),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Clock
  initial begin
    forever #10 clk = ~clk;
  end

  // Bound a value, testing the upper limit first
  function automatic longint bound_value(input longint v, input longint hi, input longint lo);
    if (v > hi) begin
      return hi;
    end else if (v < lo) begin
      return lo;
    end
    return v;
  endfunction

  // Update the register shadow on an accepted write
  function automatic void apply_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    case (idx)
      REG_KP:      kp_gain = data[GAIN_W-1:0];
      REG_KI:      ki_gain = data[GAIN_W-1:0];
      REG_KD:      kd_gain = data[GAIN_W-1:0];
      REG_OUT_MIN: drive_lo = $signed(data);
      REG_OUT_MAX: drive_hi = $signed(data);
      default: ;
    endcase
  endfunction

  // Rebuild integral bounds, rescaling the stored sum when ki moved
  function automatic void refresh_bounds();
    longint s;
    if (ki_gain == 0) begin
      accum    = 0;
      accum_hi = 0;
      accum_lo = 0;
    end else begin
      s = accum;
      if (bound_ki != 0 && bound_ki != ki_gain) begin
        s = (s * bound_ki) / ki_gain;
      end
      accum_hi = (longint'(drive_hi) * Q15_ONE) / ki_gain;
      accum_lo = (longint'(drive_lo) * Q15_ONE) / ki_gain;
      accum    = bound_value(s, accum_hi, accum_lo);
    end
    bound_ki = ki_gain;
    bound_hi = drive_hi;
    bound_lo = drive_lo;
  endfunction

  // Advance the controller shadow by one request and return its drive value
  function automatic logic signed [DATA_W-1:0] next_drive(input logic signed [DATA_W-1:0] r,
                                                          input logic signed [DATA_W-1:0] m);
    longint err, p_term, i_term, d_term, total;
    if (ki_gain != bound_ki || drive_hi != bound_hi || drive_lo != bound_lo) begin
      refresh_bounds();
    end
    err    = longint'(r) - longint'(m);
    p_term = (longint'(kp_gain) * err) / Q15_ONE;
    if (ki_gain == 0) begin
      accum  = 0;
      i_term = 0;
    end else begin
      accum  = bound_value(accum + err, accum_hi, accum_lo);
      i_term = (accum * ki_gain) / Q15_ONE;
    end
    d_term     = (kd_gain != 0) ? (longint'(kd_gain) * (err - last_error)) / Q15_ONE : 0;
    last_error = err;
    total      = bound_value(p_term + i_term + d_term, drive_hi, drive_lo);
    return DATA_W'(total);
  endfunction

  // Write one register and wait for the handshake
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, data);
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_sample(input logic signed [DATA_W-1:0] r, input logic signed [DATA_W-1:0] m);
    sample_t s;
    s.reference = r;
    s.measured  = m;
    pending_q.push_back(s);
  endtask

  // Hold until every queued request has been answered
  task automatic wait_drained();
    do @(posedge clk); while (pending_q.size() != 0 || sample_valid || drive_q.size() != 0);
  endtask

  function automatic int corner_value();
    case ($urandom_range(0, 3))
      0:       return -32768;
      1:       return 32767;
      2:       return 0;
      default: return -1;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'hFFFF;
      2:       return 16'($urandom_range(1, 64));
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly track a slowly moving setpoint; mix in noise and corner values
  task automatic queue_samples(input int count);
    int r, m;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          if ($urandom_range(0, 19) == 0) begin
            setpoint = int'($signed(16'($urandom)));
          end
          r = setpoint;
          m = setpoint + int'($urandom_range(0, 2000)) - 1000;
        end
        6, 7, 8: begin
          r = int'($signed(16'($urandom)));
          m = int'($signed(16'($urandom)));
        end
        default: begin
          r = corner_value();
          m = corner_value();
        end
      endcase
      if (m > 32767) m = 32767;
      if (m < -32768) m = -32768;
      push_sample(DATA_W'(r), DATA_W'(m));
    end
  endtask

  // Request driver: present the next queued request, with random gaps
  always @(negedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (!sample_valid || sample_fire) begin
      if (gap_left > 0) begin
        gap_left--;
        sample_valid <= 1'b0;
      end else if (!quiet && pending_q.size() != 0 && $urandom_range(0, 7) == 0) begin
        gap_left = $urandom_range(1, 18) - 1;
        sample_valid <= 1'b0;
      end else if (pending_q.size() != 0) begin
        next_sample = pending_q.pop_front();
        reference    <= next_sample.reference;
        measured     <= next_sample.measured;
        sample_valid <= 1'b1;
      end else begin
        sample_valid <= 1'b0;
      end
    end
  end

  // Result backpressure in random bursts
  always @(negedge clk) begin
    if (rst || quiet) begin
      drive_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      drive_stall <= 1'b1;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 18) - 1;
      drive_stall <= 1'b1;
    end else begin
      drive_stall <= 1'b0;
    end
  end

  // Predict on each accepted request
  always @(posedge clk) begin
    if (rst) begin
      sample_fire <= 1'b0;
    end else begin
      sample_fire <= sample_valid && !sample_stall;
      if (sample_valid && !sample_stall) begin
        drive_q.push_back(next_drive(reference, measured));
        accepted++;
      end
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    if (!rst && drive_valid && !drive_stall) begin
      if (drive_q.size() == 0) begin
        errors++;
        $error("drive: expected none, actual %0d", drive);
      end else begin
        want_drive = drive_q.pop_front();
        checked++;
        if (drive !== want_drive) begin
          errors++;
          $error("drive: expected %0d, actual %0d", want_drive, drive);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Stimulus phases
  initial begin
    int start;
    logic [DATA_W-1:0] lo_v, hi_v, tmp;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: extremes of the error range
    push_sample(16'sd0, 16'sd0);
    push_sample(16'sd32767, -16'sd32768);
    push_sample(-16'sd32768, 16'sd32767);
    push_sample(16'sd32767, 16'sd32767);
    push_sample(-16'sd32768, -16'sd32768);
    push_sample(16'sd1000, 16'sd0);
    push_sample(16'sd1000, 16'sd0);
    push_sample(-16'sd1, 16'sd0);
    push_sample(16'sd16384, -16'sd16384);
    wait_drained();

    // Zero integral gain, derivative only; a write past the register list
    write_reg(REG_KP, 16'd0);
    write_reg(REG_KI, 16'd0);
    write_reg(REG_KD, 16'h7FFF);
    write_reg(REG_LAST_CODE, 16'hA5A5);
    settings++;
    push_sample(16'sd32767, -16'sd32768);
    push_sample(-16'sd32768, 16'sd32767);
    push_sample(16'sd32767, -16'sd32768);
    push_sample(16'sd0, 16'sd0);
    wait_drained();

    // Inverted output limits
    write_reg(REG_KP, 16'h7FFF);
    write_reg(REG_KI, 16'd500);
    write_reg(REG_KD, 16'd0);
    write_reg(REG_OUT_MIN, 16'd1000);
    write_reg(REG_OUT_MAX, -16'sd1000);
    settings++;
    push_sample(16'sd20000, 16'sd0);
    push_sample(-16'sd20000, 16'sd0);
    push_sample(16'sd0, 16'sd0);
    push_sample(16'sd500, 16'sd0);
    wait_drained();

    // Full limits with unit ki, then a jump to the largest ki to force a rescale
    write_reg(REG_KP, 16'hFFFF);
    write_reg(REG_KI, 16'd1);
    write_reg(REG_KD, 16'h7FFF);
    write_reg(REG_OUT_MIN, 16'h8000);
    write_reg(REG_OUT_MAX, 16'h7FFF);
    settings++;
    push_sample(16'sd32767, -16'sd32768);
    push_sample(16'sd32767, -16'sd32768);
    push_sample(-16'sd32768, 16'sd32767);
    push_sample(16'sd32767, -16'sd32768);
    wait_drained();
    write_reg(REG_KI, 16'h7FFF);
    settings++;
    push_sample(16'sd100, 16'sd0);
    push_sample(-16'sd100, 16'sd0);
    wait_drained();

    // Random settings, each followed by a burst of requests
    for (int p = 0; p < RAND_PHASES; p++) begin
      quiet = (p == RAND_PHASES - 1);
      lo_v = 16'($urandom);
      hi_v = 16'($urandom);
      case ($urandom_range(0, 7))
        0: begin
          lo_v = 16'h8000;
          hi_v = 16'h7FFF;
        end
        1: begin
          if ($signed(hi_v) > $signed(lo_v)) begin
            tmp  = lo_v;
            lo_v = hi_v;
            hi_v = tmp;
          end
        end
        2: hi_v = lo_v;
        default: begin
          if ($signed(hi_v) < $signed(lo_v)) begin
            tmp  = lo_v;
            lo_v = hi_v;
            hi_v = tmp;
          end
        end
      endcase
      if (p == 0) begin
        lo_v = 16'h8000;
        hi_v = 16'h7FFF;
      end
      start = $urandom_range(0, REG_COUNT - 1);
      for (int k = 0; k < REG_COUNT; k++) begin
        case ((start + k) % REG_COUNT)
          REG_KP:      write_reg(REG_KP, p == 0 ? 16'h7FFF : p == 1 ? 16'h0 : pick_gain());
          REG_KI: begin
            if (p > 1 && $urandom_range(0, 2) == 0) begin
              write_reg(REG_KI, DATA_W'(ki_gain));
            end else begin
              write_reg(REG_KI, p == 0 ? 16'h7FFF : p == 1 ? 16'h0 : pick_gain());
            end
          end
          REG_KD:      write_reg(REG_KD, p == 0 ? 16'h7FFF : p == 1 ? 16'h0 : pick_gain());
          REG_OUT_MIN: write_reg(REG_OUT_MIN, lo_v);
          default:     write_reg(REG_OUT_MAX, hi_v);
        endcase
      end
      if ($urandom_range(0, 3) == 0) begin
        write_reg(IDX_W'($urandom_range(REG_COUNT, REG_LAST_CODE)), 16'($urandom));
      end
      settings++;
      queue_samples(PHASE_ITEMS);
      wait_drained();
    end

    // Let the pipeline settle, then report
    repeat (DRAIN_WAIT) @(posedge clk);
    if (drive_q.size() != 0) begin
      errors++;
      $error("drive: %0d expected results never arrived", drive_q.size());
    end
    $display("Covered %0d requests and %0d checked drive results", accepted, checked);
    $display("over %0d register settings using %0d register writes", settings, reg_writes);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
